@@ src/bsg_pkg.sv @@
`default_nettype none

package bsg_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ROW_STRIDE   = 3'd0;
    localparam logic [2:0] CFG_COLUMN_BINS  = 3'd1;
    localparam logic [2:0] CFG_BIN_SIZE_X   = 3'd2;
    localparam logic [2:0] CFG_BIN_SIZE_Y   = 3'd3;
    localparam logic [2:0] CFG_BIN_SIZE_Z   = 3'd4;
    localparam logic [2:0] CFG_HALF_MODE    = 3'd5;
    localparam logic [2:0] CFG_THREE_DIM    = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // half-space modes
    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_UPPER = 2'd1;
    localparam logic [1:0] MODE_PLANE = 2'd2;

    typedef struct packed {
        logic [2:0]  span_x;
        logic [2:0]  span_y;
        logic [2:0]  span_z;
        logic [39:0] cutoff_squared;
    } t_in_item;

    typedef struct packed {
        logic signed [27:0] bin_offset;
        logic signed [3:0]  offset_x;
        logic signed [3:0]  offset_y;
        logic signed [3:0]  offset_z;
        logic [39:0]        distance_squared;
        logic               entry_valid;
        logic               overflow;
        logic               last_entry;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLANE,
        S_KROW,
        S_GAPZ,
        S_SQZ,
        S_JROW,
        S_GAPY,
        S_SQY,
        S_GAPX,
        S_SQX,
        S_TEST,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

@@ src/bin_stencil_generator.sv @@
`default_nettype none

// Bin stencil generator. Each request (span_x/y/z, cutoff_squared) walks bin offsets with
// k outermost and i innermost and returns one item per kept offset, the final one marked
// last_entry (an empty stencil returns a single marker item). All multiplies go through
// one shared signed multiplier under a small sequencer; the sums use separate adders.
// Each candidate bin passes through a gap state, a square state, then the cutoff test;
// each new row and each new plane adds its own product, gap and square states. In the
// test state a hit with an entry held waits while the output register is full and stalled.
// The input is stalled for the whole request; a finished item may wait in the output
// register while the next request enters. Configuration is written through the plain
// write port; the user must write it only while the block is idle, unenforced by the block.
module bin_stencil_generator #(
    parameter int MAX_SPAN    = 7,
    parameter int MAX_ENTRIES = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [bsg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire [bsg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire bsg_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output bsg_pkg::t_out_item               o_out_data
);
    import bsg_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // configuration
    logic [12:0] r_row_stride;
    logic [12:0] r_column_bins;
    logic [15:0] r_bin_size_x;
    logic [15:0] r_bin_size_y;
    logic [15:0] r_bin_size_z;
    logic [1:0]  r_half_mode;
    logic        r_three_dim;

    // request and walk state
    t_state             r_state, n_state;
    logic [2:0]         r_sx, r_sy;
    logic [39:0]        r_cut;
    logic               r_upper;
    logic signed [3:0]  r_i, r_j, r_k;
    logic signed [3:0]  r_j0, r_k1;
    logic [25:0]        r_plane;
    logic [27:0]        r_kprod;
    logic [27:0]        r_lin;
    logic [18:0]        r_g;
    logic [37:0]        r_gx2, r_gy2, r_gz2;
    logic [CNT_W-1:0]   r_count;
    logic               r_over;

    // one held entry, so the last one can be marked once the walk ends
    t_out_item          r_pend;
    logic               r_pend_v;
    t_out_item          r_out;
    logic               r_out_v;
    t_out_item          last_item;

    // shared multiplier
    logic signed [26:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [46:0] prod;

    logic        in_take, out_take, out_free;
    logic        allowed, hit, room, hold, load_out;
    logic        end_i, end_j, end_k;
    logic [39:0] dist_sq;
    logic [2:0]  sx_c, sy_c, sz_c;
    logic [1:0]  mode_c;
    logic signed [3:0] sxn, syn, szn, j0_c, k0_c, k1_c;

    function automatic logic [2:0] gap_steps(input logic signed [3:0] v);
        logic [3:0] a;
        a = v[3] ? 4'(-v) : 4'(v);
        return (a == 4'd0) ? 3'd0 : 3'(a - 4'd1);
    endfunction

    function automatic logic [2:0] clamp_span(input logic [2:0] s);
        return (int'(s) > MAX_SPAN) ? 3'(MAX_SPAN) : s;
    endfunction

    assign prod     = mul_a * mul_b;
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = r_out_v && !i_out_stall;
    assign out_free = !r_out_v || !i_out_stall;

    // request decode at accept
    always_comb begin
        sx_c   = clamp_span(i_in_data.span_x);
        sy_c   = clamp_span(i_in_data.span_y);
        sz_c   = clamp_span(i_in_data.span_z);
        mode_c = (r_half_mode inside {MODE_UPPER, MODE_PLANE}) ? r_half_mode : MODE_ALL;
        sxn    = -$signed({1'b0, sx_c});
        syn    = -$signed({1'b0, sy_c});
        szn    = -$signed({1'b0, sz_c});
        if (r_three_dim) begin
            k0_c = (mode_c == MODE_ALL) ? szn : 4'sd0;
            k1_c = $signed({1'b0, sz_c});
            j0_c = syn;
        end else begin
            k0_c = 4'sd0;
            k1_c = 4'sd0;
            j0_c = (mode_c == MODE_ALL) ? syn : 4'sd0;
        end
    end

    // cutoff test of the current candidate
    always_comb begin
        dist_sq = {2'b00, r_gx2} + {2'b00, r_gy2} + {2'b00, r_gz2};
        allowed = !r_upper || (r_k > 4'sd0) || (r_j > 4'sd0)
                  || ((r_j == 4'sd0) && (r_i > 4'sd0));
        hit     = allowed && (dist_sq < r_cut);
        room    = r_count < CNT_W'(MAX_ENTRIES);
        end_i   = r_i == $signed({1'b0, r_sx});
        end_j   = r_j == $signed({1'b0, r_sy});
        end_k   = r_k == r_k1;
    end

    // final item of a request: the held entry marked last, or the empty marker
    always_comb begin
        last_item          = r_pend;
        last_item.overflow = r_over;
        if (!r_pend_v) begin
            last_item = '0;
        end
        last_item.last_entry = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_take) n_state = S_PLANE;
            S_PLANE: n_state = S_KROW;
            S_KROW:  n_state = S_GAPZ;
            S_GAPZ:  n_state = S_SQZ;
            S_SQZ:   n_state = S_JROW;
            S_JROW:  n_state = S_GAPY;
            S_GAPY:  n_state = S_SQY;
            S_SQY:   n_state = S_GAPX;
            S_GAPX:  n_state = S_SQX;
            S_SQX:   n_state = S_TEST;
            S_TEST: begin
                if (!hold) begin
                    if (!end_i)      n_state = S_GAPX;
                    else if (!end_j) n_state = S_JROW;
                    else if (!end_k) n_state = S_KROW;
                    else             n_state = S_FLUSH;
                end
            end
            S_FLUSH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: multiplier operands and handshake
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        o_in_stall = r_state != S_IDLE;
        hold       = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_PLANE: begin
                mul_a = $signed({14'd0, r_row_stride});
                mul_b = $signed({7'd0, r_column_bins});
            end
            S_KROW: begin
                mul_a = $signed({1'b0, r_plane});
                mul_b = 20'(r_k);
            end
            S_GAPZ: begin
                mul_a = $signed({11'd0, r_bin_size_z});
                mul_b = $signed({17'd0, gap_steps(r_k)});
            end
            S_JROW: begin
                mul_a = $signed({14'd0, r_row_stride});
                mul_b = 20'(r_j);
            end
            S_GAPY: begin
                mul_a = $signed({11'd0, r_bin_size_y});
                mul_b = $signed({17'd0, gap_steps(r_j)});
            end
            S_GAPX: begin
                mul_a = $signed({11'd0, r_bin_size_x});
                mul_b = $signed({17'd0, gap_steps(r_i)});
            end
            S_SQZ, S_SQY, S_SQX: begin
                mul_a = $signed({8'd0, r_g});
                mul_b = $signed({1'b0, r_g});
            end
            S_TEST: begin
                hold     = hit && room && r_pend_v && !out_free;
                load_out = hit && room && r_pend_v && out_free;
            end
            S_FLUSH: load_out = out_free;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_row_stride  <= 13'd1;
            r_column_bins <= 13'd1;
            r_bin_size_x  <= 16'd256;
            r_bin_size_y  <= 16'd256;
            r_bin_size_z  <= 16'd256;
            r_half_mode   <= MODE_ALL;
            r_three_dim   <= 1'b1;
            r_i           <= '0;
            r_j           <= '0;
            r_k           <= '0;
            r_count       <= '0;
            r_over        <= 1'b0;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_STRIDE:  r_row_stride  <= i_cfg_data[12:0];
                    CFG_COLUMN_BINS: r_column_bins <= i_cfg_data[12:0];
                    CFG_BIN_SIZE_X:  r_bin_size_x  <= i_cfg_data;
                    CFG_BIN_SIZE_Y:  r_bin_size_y  <= i_cfg_data;
                    CFG_BIN_SIZE_Z:  r_bin_size_z  <= i_cfg_data;
                    CFG_HALF_MODE:   r_half_mode   <= i_cfg_data[1:0];
                    CFG_THREE_DIM:   r_three_dim   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_i      <= sxn;
                        r_j      <= j0_c;
                        r_k      <= k0_c;
                        r_count  <= '0;
                        r_over   <= 1'b0;
                        r_pend_v <= 1'b0;
                    end
                end
                S_TEST: begin
                    if (!hold) begin
                        if (hit) begin
                            if (room) begin
                                r_pend_v <= 1'b1;
                                r_count  <= r_count + CNT_W'(1);
                            end else begin
                                r_over <= 1'b1;
                            end
                        end
                        // advance the walk: i fastest, then j, then k
                        if (!end_i) begin
                            r_i <= r_i + 4'sd1;
                        end else if (!end_j) begin
                            r_i <= -$signed({1'b0, r_sx});
                            r_j <= r_j + 4'sd1;
                        end else if (!end_k) begin
                            r_i <= -$signed({1'b0, r_sx});
                            r_j <= r_j0;
                            r_k <= r_k + 4'sd1;
                        end
                    end
                end
                S_FLUSH: if (out_free) r_pend_v <= 1'b0;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_sx    <= sx_c;
                    r_sy    <= sy_c;
                    r_cut   <= i_in_data.cutoff_squared;
                    r_upper <= mode_c == MODE_UPPER;
                    r_j0    <= j0_c;
                    r_k1    <= k1_c;
                end
            end
            S_PLANE: r_plane <= prod[25:0];
            S_KROW:  r_kprod <= prod[27:0];
            S_GAPZ, S_GAPY, S_GAPX: r_g <= prod[18:0];
            S_SQZ:   r_gz2 <= prod[37:0];
            S_SQY:   r_gy2 <= prod[37:0];
            S_SQX:   r_gx2 <= prod[37:0];
            S_JROW:  r_lin <= r_kprod + prod[27:0] + 28'(r_i);
            S_TEST: begin
                if (!hold) begin
                    if (hit && room) begin
                        r_pend.bin_offset       <= r_lin;
                        r_pend.offset_x         <= r_i;
                        r_pend.offset_y         <= r_j;
                        r_pend.offset_z         <= r_k;
                        r_pend.distance_squared <= dist_sq;
                        r_pend.entry_valid      <= 1'b1;
                        r_pend.overflow         <= 1'b0;
                        r_pend.last_entry       <= 1'b0;
                    end
                    if (!end_i) r_lin <= r_lin + 28'd1;
                end
                if (load_out) r_out <= r_pend;
            end
            S_FLUSH: if (load_out) r_out <= last_item;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_overflow_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |-> o_out_data.last_entry)
        else $error("overflow flagged on an item that is not last");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.entry_valid |-> o_out_data.last_entry)
        else $error("empty marker not marked last");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("emitted count beyond limit");

    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> r_count != '0)
        else $error("held entry without a count");

endmodule

`default_nettype wire
